// ===== design/modinv_pkg.sv =====
package modinv_pkg;

   // Width of every value and result field on the ports.
   localparam int FIELD_WIDTH = 32;

   // Default width of the arithmetic inside the block.
   localparam int OPERAND_WIDTH_DEF = 32;

endpackage

// ===== design/modular_inverse.sv =====
// Sequence per item: a check state per remainder step, an align state that doubles the
// divisor up to the remainder, and a subtract state that halves it back one quotient bit at
// a time; a final check then leads to the finish state, which reduces and writes the result.
// A new request is taken only in idle, so no item is taken before the last one is finished.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module modular_inverse #(
   parameter int OPERAND_WIDTH = modinv_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*modinv_pkg::FIELD_WIDTH-1:0] req_tdata,  // value, modulus
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [modinv_pkg::FIELD_WIDTH-1:0]   rsp_tdata,  // inverse
   output logic                                 rsp_tuser   // status
);
   import modinv_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int SW = OPERAND_WIDTH + 2;
   localparam int CW = (OPERAND_WIDTH < FIELD_WIDTH) ? OPERAND_WIDTH : FIELD_WIDTH;
   localparam int KW = $clog2(OPERAND_WIDTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_ALIGN  = 3'd2;
   localparam logic [2:0] ST_SUB    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [W-1:0]         r0_ff, r0_in, r1_ff, r1_in, rem_ff, rem_in, d_ff, d_in;
   logic [W-1:0]         m_ff, m_in;
   logic signed [SW-1:0] s0_ff, s0_in, s1_ff, s1_in, sd_ff, sd_in, sacc_ff, sacc_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 mzero_ff, mzero_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in, rsp_status_ff, rsp_status_in;
   logic [W-1:0]         rsp_inv_ff, rsp_inv_in;

   // Shared datapath: one compare-subtract on the remainder, one on the coefficient.
   logic [W:0]           op;
   logic [W+1:0]         diff;
   logic                 ge;
   logic signed [SW-1:0] sdiff, inv_full;
   logic                 out_free, fail;

   assign op       = (state_ff == ST_ALIGN) ? {d_ff, 1'b0} : {1'b0, d_ff};
   assign diff     = {2'b00, rem_ff} - {1'b0, op};
   assign ge       = !diff[W+1];
   assign sdiff    = sacc_ff - sd_ff;
   assign inv_full = s0_ff[SW-1] ? (s0_ff + $signed({2'b00, m_ff})) : s0_ff;
   assign fail     = mzero_ff || (r0_ff != W'(1));
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      rem_in        = rem_ff;
      d_in          = d_ff;
      sd_in         = sd_ff;
      sacc_in       = sacc_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      mzero_in      = mzero_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_inv_in    = rsp_inv_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               r0_in    = W'(req_tdata[CW-1:0]);
               r1_in    = W'(req_tdata[FIELD_WIDTH +: CW]);
               m_in     = W'(req_tdata[FIELD_WIDTH +: CW]);
               mzero_in = (req_tdata[FIELD_WIDTH +: CW] == '0);
               s0_in    = SW'(1);
               s1_in    = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (r1_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rem_in   = r0_ff;
               d_in     = r1_ff;
               sd_in    = s1_ff;
               sacc_in  = s0_ff;
               k_in     = '0;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // Double the divisor while the doubled divisor still fits under the remainder.
            if (ge) begin
               d_in  = {d_ff[W-2:0], 1'b0};
               sd_in = sd_ff <<< 1;
               k_in  = k_ff + KW'(1);
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (ge) begin
               rem_in  = diff[W-1:0];
               sacc_in = sdiff;
            end
            if (k_ff == '0) begin
               r0_in    = r1_ff;
               r1_in    = ge ? diff[W-1:0] : rem_ff;
               s0_in    = s1_ff;
               s1_in    = ge ? sdiff : sacc_ff;
               state_in = ST_CHECK;
            end else begin
               d_in  = d_ff >> 1;
               sd_in = sd_ff >>> 1;
               k_in  = k_ff - KW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = fail;
               rsp_inv_in    = fail ? '0 : inv_full[W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      s0_ff         <= s0_in;
      s1_ff         <= s1_in;
      rem_ff        <= rem_in;
      d_ff          <= d_in;
      sd_ff         <= sd_in;
      sacc_ff       <= sacc_in;
      k_ff          <= k_in;
      m_ff          <= m_in;
      mzero_ff      <= mzero_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = FIELD_WIDTH'(rsp_inv_ff[CW-1:0]);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== design/modinv_checker.sv =====
module modinv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [modinv_pkg::FIELD_WIDTH-1:0] rsp_tdata,  // inverse
   input logic                               rsp_tuser   // status
);
   import modinv_pkg::*;

   // A failed inversion always reports a zero inverse.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("no-inverse beat carries a nonzero inverse");

   // The block works on one item at a time, so it is busy right after a beat is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // A result cannot be produced in the cycle right after an input is taken.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind modular_inverse modinv_checker u_modinv_checker (.*);
